// ----- src/blte_pkg.sv -----
// shared types and constants for the bounded list table engine
`default_nettype none
package blte_pkg;
  localparam int POOL_SIZE = 16;
  localparam int IDX_W     = $clog2(POOL_SIZE);
  localparam int CNT_W     = IDX_W + 1;
  localparam int POS_W     = 4;
  localparam int VAL_W     = 32;

  typedef enum logic [2:0] {
    KIND_CLEAR  = 3'd0,
    KIND_APPEND = 3'd1,
    KIND_DELETE = 3'd2,
    KIND_SORT   = 3'd3,
    KIND_SEARCH = 3'd4,
    KIND_LIST   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_TOO_SHORT = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EX,
    S_RDI,
    S_LDI,
    S_SWR
  } state_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] item_value;
    logic [3:0]         position;
    logic               last;
  } out_item_t;
endpackage
`default_nettype wire

// ----- src/blte_ram.sv -----
// single write port, single registered read port entry memory
`default_nettype none
module blte_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- src/bounded_list_table_engine_core.sv -----
// bounded list table engine: list kept in one entry memory, walked by a sequencer
// clear and append answer straight from idle; delete, search and list walk the
// entries (read, then compare or emit); sort orders the entries ascending, signed
// one item is worked at a time; each registered read is used in the state after it
// synchronous reset empties the list and frees all slots; memory contents are not cleared
`default_nettype none
module bounded_list_table_engine_core
  import blte_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);
  state_t state, state_next;

  logic [CNT_W-1:0] list_length;
  logic [CNT_W-1:0] slots_used;
  logic [CNT_W-1:0] i, j, w;
  logic [2:0]       op;
  logic [31:0]      val;
  logic [31:0]      cur;
  logic             hit;

  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  logic [31:0]      wdata, rdata;

  logic      out_free, accept, last_j, match, gt, ex_emit, ex_wait, ex_done, sort_end;
  logic      out_load;
  out_item_t out_next;

  blte_ram #(.DEPTH(POOL_SIZE), .WIDTH(VAL_W)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !(state == S_IDLE && out_free);
  assign accept   = in_valid && !in_stall;
  assign last_j   = (CNT_W'(j + 1'b1) == list_length);
  assign match    = (rdata == val);
  assign gt       = ($signed(cur) > $signed(rdata));
  assign sort_end = (CNT_W'(i + 2'd2) == list_length);

  always_comb begin
    ex_emit = 1'b0;
    ex_done = 1'b0;
    case (op)
      KIND_DELETE: begin ex_emit = last_j; ex_done = last_j; end
      KIND_SEARCH: begin ex_emit = match || last_j; ex_done = match || last_j; end
      KIND_LIST:   begin ex_emit = 1'b1; ex_done = last_j; end
      default:     begin ex_emit = 1'b0; ex_done = 1'b0; end
    endcase
  end
  assign ex_wait = ex_emit && !out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_data.kind)
            KIND_DELETE, KIND_SEARCH, KIND_LIST:
              state_next = (list_length == '0) ? S_IDLE : S_RD;
            KIND_SORT:
              state_next = (list_length < CNT_W'(2)) ? S_IDLE : S_RDI;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RD:  state_next = S_EX;
      S_EX: begin
        if (op == KIND_SORT) begin
          state_next = last_j ? S_SWR : S_RD;
        end else if (ex_wait) begin
          state_next = S_EX;
        end else begin
          state_next = ex_done ? S_IDLE : S_RD;
        end
      end
      S_RDI: state_next = S_LDI;
      S_LDI: state_next = S_RD;
      S_SWR: begin
        if (sort_end) begin
          state_next = out_free ? S_IDLE : S_SWR;
        end else begin
          state_next = S_RDI;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory port and result outputs
  always_comb begin
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    re       = 1'b0;
    raddr    = '0;
    out_load = 1'b0;
    out_next = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          out_next.last = 1'b1;
          case (in_data.kind)
            KIND_CLEAR: begin
              out_load        = 1'b1;
              out_next.status = ST_OK;
            end
            KIND_APPEND: begin
              out_load            = 1'b1;
              out_next.item_value = in_data.value;
              if (slots_used >= CNT_W'(POOL_SIZE)) begin
                out_next.status = ST_FULL;
              end else begin
                out_next.status = ST_OK;
                we    = 1'b1;
                waddr = list_length[IDX_W-1:0];
                wdata = in_data.value;
              end
            end
            KIND_DELETE: begin
              out_load            = (list_length == '0);
              out_next.status     = ST_EMPTY;
              out_next.item_value = in_data.value;
            end
            KIND_SORT: begin
              out_load        = (list_length < CNT_W'(2));
              out_next.status = ST_TOO_SHORT;
            end
            KIND_SEARCH: begin
              out_load            = (list_length == '0);
              out_next.status     = ST_NOT_FOUND;
              out_next.item_value = in_data.value;
            end
            KIND_LIST: begin
              out_load        = (list_length == '0);
              out_next.status = ST_EMPTY;
            end
            default: out_load = 1'b0;
          endcase
        end
      end
      S_RD: begin
        re    = 1'b1;
        raddr = j[IDX_W-1:0];
      end
      S_RDI: begin
        re    = 1'b1;
        raddr = i[IDX_W-1:0];
      end
      S_EX: begin
        case (op)
          KIND_SORT: begin
            // larger entry goes back to j, the running minimum stays in cur
            we    = gt;
            waddr = j[IDX_W-1:0];
            wdata = cur;
          end
          KIND_DELETE: begin
            we    = !match && !ex_wait;
            waddr = w[IDX_W-1:0];
            wdata = rdata;
            out_load            = ex_emit && out_free;
            out_next.status     = (hit || match) ? ST_OK : ST_NOT_FOUND;
            out_next.item_value = val;
            out_next.last       = 1'b1;
          end
          KIND_SEARCH: begin
            out_load            = ex_emit && out_free;
            out_next.status     = match ? ST_OK : ST_NOT_FOUND;
            out_next.item_value = val;
            out_next.position   = match ? POS_W'(j) : '0;
            out_next.last       = 1'b1;
          end
          KIND_LIST: begin
            out_load            = out_free;
            out_next.status     = ST_OK;
            out_next.item_value = rdata;
            out_next.position   = POS_W'(j);
            out_next.last       = last_j;
          end
          default: out_load = 1'b0;
        endcase
      end
      S_SWR: begin
        we    = 1'b1;
        waddr = i[IDX_W-1:0];
        wdata = cur;
        out_load        = sort_end && out_free;
        out_next.status = ST_OK;
        out_next.last   = 1'b1;
      end
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      list_length <= '0;
      slots_used  <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_IDLE && accept) begin
        if (in_data.kind == KIND_CLEAR) begin
          list_length <= '0;
          slots_used  <= '0;
        end else if (in_data.kind == KIND_APPEND && slots_used < CNT_W'(POOL_SIZE)) begin
          list_length <= CNT_W'(list_length + 1'b1);
          slots_used  <= CNT_W'(slots_used + 1'b1);
        end
      end
      if (state == S_EX && op == KIND_DELETE && last_j && !ex_wait) begin
        list_length <= match ? w : CNT_W'(w + 1'b1);
      end
    end
  end

  // scan registers and the result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
    case (state)
      S_IDLE: begin
        op  <= in_data.kind;
        val <= in_data.value;
        i   <= '0;
        j   <= '0;
        w   <= '0;
        hit <= 1'b0;
      end
      S_LDI: begin
        cur <= rdata;
        j   <= CNT_W'(i + 1'b1);
      end
      S_EX: begin
        if (op == KIND_SORT) begin
          if (gt) begin
            cur <= rdata;
          end
          j <= CNT_W'(j + 1'b1);
        end else if (!ex_wait) begin
          j <= CNT_W'(j + 1'b1);
          if (match) begin
            hit <= 1'b1;
          end else begin
            w <= CNT_W'(w + 1'b1);
          end
        end
      end
      S_SWR: begin
        if (!sort_end) begin
          i <= CNT_W'(i + 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

  a_len_le_used: assert property (@(posedge clk) disable iff (rst)
    list_length <= slots_used) else $error("list longer than slots used");
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= CNT_W'(POOL_SIZE)) else $error("slots used beyond pool");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result lost");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EX) |-> (j < list_length)) else $error("walk past list end");
endmodule
`default_nettype wire
